// File: rtl/assert_macros.svh
// Assertion helpers used by brr_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while arst_n is low.
`define BRR_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define BRR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/brr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_pkg
// Shared constants, types and the per-range quantizer of the BRR encoder.
// ----------------------------------------------------------------------------
package brr_pkg;

	localparam int BLOCK_SAMPLES = 16;
	localparam int NUM_RANGES    = 13;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int DEV_W    = 15;
	localparam int SUM_W    = 19;
	localparam int MARK_W   = 4;
	localparam int BYTE_W   = 8;
	localparam int HDR_RNG_W = 4;

	localparam int COL_W   = $clog2(BLOCK_SAMPLES);
	localparam int PAIRS   = (BLOCK_SAMPLES + 1) / 2;
	localparam int PAIR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int POS_W   = $clog2(PAIRS + 1);
	localparam int RIDX_W  = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;

	// Four block buffers: one filling, the rest queued or draining.
	localparam int NUM_BANKS = 4;
	localparam int BANK_W    = 2;
	localparam int OCC_W     = $clog2(NUM_BANKS + 1);
	localparam int ADDR_W    = BANK_W + PAIR_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	localparam int TREE_LVLS = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 0;
	localparam int TREE_W    = 1 << TREE_LVLS;
	localparam int TREE_N    = 2 * TREE_W - 1;

	localparam logic [MAG_W-1:0] MAG_LIM_POS = MAG_W'(7);
	localparam logic [MAG_W-1:0] MAG_LIM_NEG = MAG_W'(8);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       final_block;
	} brr_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_block;
	} brr_out_t;

	typedef logic [NUM_RANGES-1:0][MARK_W-1:0] mark_row_t;
	typedef logic [NUM_RANGES-1:0][BYTE_W-1:0] pair_row_t;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [RIDX_W-1:0] range;
		logic              end_flag;
	} brr_desc_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		pair_row_t         data;
	} brr_wr_t;

	typedef struct packed {
		logic [MARK_W-1:0] mark;
		logic [DEV_W-1:0]  dev;
	} brr_quant_t;

	typedef enum logic {
		BK_IDLE,
		BK_SEND
	} bk_state_t;

	// Nearest mark on the grid k * 2^r, ties toward zero, clamped to 0..7
	// for positive and -8..0 for negative samples.
	function automatic brr_quant_t brr_quant(input logic [SAMPLE_W-1:0] v, input int r);
		brr_quant_t        res;
		logic              neg;
		logic              up;
		logic [MAG_W-1:0]  a;
		logic [MAG_W-1:0]  mask;
		logic [MAG_W-1:0]  q;
		logic [MAG_W-1:0]  rem;
		logic [MAG_W-1:0]  half;
		logic [MAG_W-1:0]  mag;
		logic [MAG_W-1:0]  lim;
		logic [MAG_W-1:0]  dev;
		neg  = v[SAMPLE_W-1];
		a    = neg ? ({1'b0, ~v} + MAG_W'(1)) : {1'b0, v};
		mask = (MAG_W'(1) << r) - MAG_W'(1);
		q    = a >> r;
		rem  = a & mask;
		half = (mask + MAG_W'(1)) >> 1;
		up   = (r > 0) && (rem > half);
		mag  = q + MAG_W'(up);
		lim  = neg ? MAG_LIM_NEG : MAG_LIM_POS;
		if (mag > lim) begin
			dev = a - (lim << r);
			mag = lim;
		end else if (up) begin
			dev = mask - rem + MAG_W'(1);
		end else begin
			dev = rem;
		end
		res.mark = neg ? MARK_W'(MAG_W'(0) - mag) : MARK_W'(mag);
		res.dev  = DEV_W'(dev);
		return res;
	endfunction

endpackage
`default_nettype wire

// File: rtl/brr_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_store
// Nibble-pair buffer: one row per byte slot holds that byte for every range.
// ----------------------------------------------------------------------------
module brr_store import brr_pkg::*; (
	input  wire logic              clk,
	input  wire brr_wr_t           wr,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output pair_row_t              rd_data
);

	pair_row_t mem_q [MEM_DEPTH];
	pair_row_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

// File: rtl/brr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_front
// Sample intake, per-range quantizing, deviation sums and best-range tree.
// ----------------------------------------------------------------------------
module brr_front import brr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire brr_in_t in_data,
	input  wire logic    release_bank,
	output brr_wr_t      wr,
	output logic         desc_valid,
	output brr_desc_t    desc
);

	logic [COL_W-1:0]  col_q;
	logic [BANK_W-1:0] bank_q;
	logic [OCC_W-1:0]  occ_q;
	logic              fire;
	logic              last_in;
	logic              alloc;

	assign in_ready = (col_q != '0) || (occ_q < OCC_W'(NUM_BANKS));
	assign fire     = in_valid && in_ready;
	assign last_in  = (col_q == COL_W'(BLOCK_SAMPLES - 1));
	assign alloc    = fire && (col_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			bank_q <= '0;
			occ_q  <= '0;
		end else begin
			if (fire) begin
				col_q <= last_in ? '0 : col_q + COL_W'(1);
				if (last_in) begin
					bank_q <= bank_q + BANK_W'(1);
				end
			end
			occ_q <= occ_q + OCC_W'(alloc) - OCC_W'(release_bank);
		end
	end

	// stage 1: registered sample
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                final_s1;
	logic [COL_W-1:0]    col_s1;
	logic [BANK_W-1:0]   bank_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_s1 <= in_data.sample;
			final_s1  <= in_data.final_block;
			col_s1    <= col_q;
			bank_s1   <= bank_q;
		end
	end

	// one quantizer lane per range
	brr_quant_t qres [NUM_RANGES];

	always_comb begin
		for (int r = 0; r < NUM_RANGES; r++) begin
			qres[r] = brr_quant(sample_s1, r);
		end
	end

	// stage 2: marks and deviations
	logic              valid_s2;
	mark_row_t         marks_s2;
	logic [DEV_W-1:0]  devs_s2 [NUM_RANGES];
	logic              final_s2;
	logic [COL_W-1:0]  col_s2;
	logic [BANK_W-1:0] bank_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int r = 0; r < NUM_RANGES; r++) begin
				marks_s2[r] <= qres[r].mark;
				devs_s2[r]  <= qres[r].dev;
			end
			final_s2 <= final_s1;
			col_s2   <= col_s1;
			bank_s2  <= bank_s1;
		end
	end

	logic             last_s2;
	logic [SUM_W-1:0] sums_q [NUM_RANGES];
	logic [SUM_W-1:0] sum_nx [NUM_RANGES];
	logic [SUM_W-1:0] sum_pad [TREE_W];
	logic             end_q;
	mark_row_t        even_q;

	assign last_s2 = valid_s2 && (col_s2 == COL_W'(BLOCK_SAMPLES - 1));

	always_comb begin
		for (int r = 0; r < NUM_RANGES; r++) begin
			sum_nx[r] = sums_q[r] + SUM_W'(devs_s2[r]);
		end
		for (int i = 0; i < TREE_W; i++) begin
			sum_pad[i] = '1;
		end
		for (int r = 0; r < NUM_RANGES; r++) begin
			sum_pad[r] = sum_nx[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_RANGES; r++) begin
				sums_q[r] <= '0;
			end
			end_q <= 1'b0;
		end else if (valid_s2) begin
			for (int r = 0; r < NUM_RANGES; r++) begin
				sums_q[r] <= last_s2 ? '0 : sum_nx[r];
			end
			end_q <= last_s2 ? 1'b0 : (end_q | final_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && !col_s2[0]) begin
			even_q <= marks_s2;
		end
	end

	// a byte row is written on its odd sample, or on a lone even last sample
	always_comb begin
		wr.en   = valid_s2 && (col_s2[0] || last_s2);
		wr.addr = {bank_s2, PAIR_W'(col_s2 >> 1)};
		for (int r = 0; r < NUM_RANGES; r++) begin
			wr.data[r] = col_s2[0] ? {even_q[r], marks_s2[r]} : {marks_s2[r], MARK_W'(0)};
		end
	end

	// registered min tree, heap order: node n has children 2n+1 and 2n+2;
	// left wins ties so the lowest range is kept
	logic [SUM_W-1:0]  nd_sum_q [TREE_N];
	logic [RIDX_W-1:0] nd_idx_q [TREE_N];
	logic              tv_q [TREE_LVLS+1];
	logic [BANK_W-1:0] tb_q [TREE_LVLS+1];
	logic              te_q [TREE_LVLS+1];

	always_ff @(posedge clk) begin
		for (int n = 0; n < TREE_W - 1; n++) begin
			if (nd_sum_q[2*n+2] < nd_sum_q[2*n+1]) begin
				nd_sum_q[n] <= nd_sum_q[2*n+2];
				nd_idx_q[n] <= nd_idx_q[2*n+2];
			end else begin
				nd_sum_q[n] <= nd_sum_q[2*n+1];
				nd_idx_q[n] <= nd_idx_q[2*n+1];
			end
		end
		if (last_s2) begin
			for (int i = 0; i < TREE_W; i++) begin
				nd_sum_q[TREE_W-1+i] <= sum_pad[i];
				nd_idx_q[TREE_W-1+i] <= RIDX_W'(i);
			end
		end
		tb_q[0] <= bank_s2;
		te_q[0] <= end_q | final_s2;
		for (int l = 1; l <= TREE_LVLS; l++) begin
			tb_q[l] <= tb_q[l-1];
			te_q[l] <= te_q[l-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= TREE_LVLS; l++) begin
				tv_q[l] <= 1'b0;
			end
		end else begin
			tv_q[0] <= last_s2;
			for (int l = 1; l <= TREE_LVLS; l++) begin
				tv_q[l] <= tv_q[l-1];
			end
		end
	end

	assign desc_valid    = tv_q[TREE_LVLS];
	assign desc.bank     = tb_q[TREE_LVLS];
	assign desc.range    = nd_idx_q[0];
	assign desc.end_flag = te_q[TREE_LVLS];

endmodule
`default_nettype wire

// File: rtl/brr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_queue
// Block descriptor FIFO between front and back. Each entry owns a bank, so
// it cannot overflow.
// ----------------------------------------------------------------------------
module brr_queue import brr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire brr_desc_t din,
	input  wire logic      pop,
	output brr_desc_t      dout,
	output logic           empty
);

	brr_desc_t         ent_q [NUM_BANKS];
	logic [BANK_W-1:0] wp_q;
	logic [BANK_W-1:0] rp_q;
	logic [OCC_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + BANK_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + BANK_W'(1);
			end
			cnt_q <= cnt_q + OCC_W'(push) - OCC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	assign dout  = ent_q[rp_q];
	assign empty = (cnt_q == '0);

endmodule
`default_nettype wire

// File: rtl/brr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_back
// Packet sequencer: header, then one buffer read per byte, into a two-entry
// output buffer.
// ----------------------------------------------------------------------------
module brr_back import brr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire brr_desc_t         q_dout,
	output logic                   q_pop,
	output logic                   rd_en,
	output logic [ADDR_W-1:0]      rd_addr,
	input  wire pair_row_t         rd_data,
	output logic                   release_bank,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output brr_out_t               out_data
);

	bk_state_t        st_q;
	bk_state_t        st_d;
	brr_desc_t        cur_q;
	logic [POS_W-1:0] pos_q;
	logic             issue;
	logic             room;
	logic             at_last;

	// output buffer
	brr_out_t         ob_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             pop;
	logic [2:0]       occ;

	// read stage
	logic              valid_s1;
	logic              hdr_s1;
	logic              last_s1;
	logic [RIDX_W-1:0] rng_s1;
	logic              end_s1;
	brr_out_t          res_s1;

	assign at_last = (pos_q == POS_W'(PAIRS));
	assign pop     = out_valid && out_ready;
	assign occ     = 3'(cnt_q) + 3'(valid_s1);
	assign room    = occ <= (3'd1 + 3'(pop));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					st_d = BK_SEND;
				end
			end
			BK_SEND: begin
				if (issue && at_last) begin
					st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		issue = 1'b0;
		unique case (st_q)
			BK_IDLE: q_pop = !q_empty;
			BK_SEND: issue = room;
			default: ;
		endcase
	end

	assign rd_en        = issue && (pos_q != '0);
	assign rd_addr      = {cur_q.bank, PAIR_W'(pos_q - POS_W'(1))};
	assign release_bank = issue && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BK_IDLE;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			st_q     <= st_d;
			valid_s1 <= issue;
			if (q_pop) begin
				pos_q <= '0;
			end else if (issue) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_dout;
		end
		if (issue) begin
			hdr_s1  <= (pos_q == '0);
			last_s1 <= at_last;
			rng_s1  <= cur_q.range;
			end_s1  <= cur_q.end_flag;
		end
	end

	always_comb begin
		res_s1.out_byte      = hdr_s1 ? {HDR_RNG_W'(rng_s1), 3'b000, end_s1} : rd_data[rng_s1];
		res_s1.last_of_block = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(valid_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ob_q[wp_q] <= res_s1;
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_data  = ob_q[rp_q];

endmodule
`default_nettype wire

// File: rtl/brr_block_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_block_encoder_core
// BRR block encoder, filter 0: quantizes each sample for all ranges, picks
// the range with least total deviation per block and emits header + nibbles.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | payload
//  --------+--------------------------------+----------------------------------
//  in      | in_valid / in_ready            | in_data  (sample, final_block)
//  out     | out_valid / out_ready          | out_data (out_byte, last_of_block)
//
//  - One sample per cycle sustained; in_ready drops only at a block start
//    while all four block buffers are still held by earlier blocks.
//  - A packet of PAIRS+1 bytes leaves at most one byte per cycle; between
//    packets the back end passes its idle state for the descriptor pop; the
//    back end is bound by the single buffer read port.
//  - out_valid for the header of a block follows its last sample through the
//    front stages, min tree, queue and back end, when the back end is idle.
//  - Reset is immediate: no clearing pass; buffers are written before read.
//  - The output register takes new bytes while out_ready is low, up to two.
//
module brr_block_encoder_core import brr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire brr_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output brr_out_t      out_data
);

	// front -> buffer memory
	brr_wr_t           wr;
	// front -> descriptor queue
	logic              desc_valid;
	brr_desc_t         desc;
	// queue -> back
	brr_desc_t         q_dout;
	logic              q_empty;
	logic              q_pop;
	// back -> buffer memory
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	pair_row_t         rd_data;
	// back -> front, frees a block buffer
	logic              release_bank;

	brr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.release_bank (release_bank),
		.wr           (wr),
		.desc_valid   (desc_valid),
		.desc         (desc)
	);

	brr_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	brr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (desc_valid),
		.din    (desc),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	brr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_dout       (q_dout),
		.q_pop        (q_pop),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.release_bank (release_bank),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule
`default_nettype wire

// File: rtl/brr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_checker
// Port-level checks on output stability and packet framing, bound to the encoder top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brr_checker import brr_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire brr_out_t out_data
);

	logic             in_fire;
	logic             out_fire;
	logic             out_stall;
	logic             ccol_end;
	logic             blk_done;
	logic             hdr_fire;
	logic             hdr_ok;
	logic             last_ok;
	logic [COL_W-1:0] ccol_q;
	logic [POS_W-1:0] bidx_q;
	logic [3:0]       pend_q;

	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign out_stall = out_valid && !out_ready;
	assign ccol_end  = (ccol_q == COL_W'(BLOCK_SAMPLES - 1));
	assign blk_done  = in_fire && ccol_end;
	assign hdr_fire  = out_fire && (bidx_q == '0);
	assign hdr_ok    = (out_data.out_byte[3:1] == 3'b000) &&
		(out_data.out_byte[7:4] < 4'(NUM_RANGES)) && !out_data.last_of_block;
	assign last_ok   = (out_data.last_of_block == (bidx_q == POS_W'(PAIRS)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccol_q <= '0;
			bidx_q <= '0;
			pend_q <= '0;
		end else begin
			if (in_fire) begin
				ccol_q <= ccol_end ? '0 : ccol_q + COL_W'(1);
			end
			if (out_fire) begin
				bidx_q <= out_data.last_of_block ? '0 : bidx_q + POS_W'(1);
			end
			pend_q <= pend_q + 4'(blk_done) - 4'(hdr_fire);
		end
	end

	`BRR_ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(out_data), "stalled output changed")
	`BRR_ASSERT_CLK(a_hdr_form, hdr_fire |-> hdr_ok, "malformed header byte")
	`BRR_ASSERT_CLK(a_last_pos, out_fire |-> last_ok, "last_of_block on wrong byte")
	`BRR_ASSERT_CLK(a_no_early, hdr_fire |-> pend_q != 4'd0, "packet before its block completed")

endmodule

bind brr_block_encoder_core brr_checker u_brr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// File: tb/tb_brr_block_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brr_block_encoder_core
// Self-checking bench for the BRR block encoder. Samples go in as requests
// over valid/ready, a behavioral encoder predicts the nine bytes of every
// completed block, and each byte that leaves the block is compared field by
// field against the oldest prediction. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_brr_block_encoder_core;
	import brr_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RAND_BLOCKS  = 25;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;
	// idling stops once this few requests are left to send
	localparam int QUIET_TAIL   = 64;

	typedef enum int {
		KIND_FULL,    // any 16-bit value
		KIND_SCALED,  // amplitude sized to one range, with tie points
		KIND_EXTREME, // full scale, zero and unit values
		KIND_FLAT     // one value repeated
	} block_kind_t;

	// DUT ports
	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	brr_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	brr_out_t out_data;

	// stimulus and scoreboard
	brr_in_t  pending_samples [$];
	brr_out_t expected_bytes  [$];
	int       samples_total  = 0;
	int       samples_taken  = 0;
	int       bytes_seen     = 0;
	int       error_count    = 0;
	int       cycle_count    = 0;
	int       in_idle_left   = 0;
	int       out_idle_left  = 0;
	bit       in_fire        = 1'b0;

	// predictor state: one block in flight
	int                 block_fill = 0;
	logic [MARK_W-1:0]  mark_tab [NUM_RANGES][BLOCK_SAMPLES];
	logic [SUM_W-1:0]   dev_sum  [NUM_RANGES];
	bit                 end_seen = 1'b0;

	brr_block_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Nearest grid point n * 2^r with n in 0..7 (positive) or -8..0
	// (negative). Search outward from zero with a strict compare, so a tie
	// keeps the smaller magnitude.
	function automatic void nearest_mark(input int v, input int r,
			output int mark, output int dev);
		int step;
		int lim;
		int cand;
		int d;
		step = 1 << r;
		lim  = (v < 0) ? 8 : 7;
		mark = 0;
		dev  = 32'hffff;
		if (v == 0) begin
			dev = 0;
		end else begin
			for (int n = 0; n <= lim; n++) begin
				cand = (v < 0) ? -n : n;
				d    = cand * step - v;
				if (d < 0)
					d = -d;
				if (d < dev) begin
					dev  = d;
					mark = cand;
				end
			end
		end
	endfunction

	// Quantize one accepted sample for every range; on the block's last
	// sample pick the range and queue header plus nibble-pair bytes.
	task automatic encode_sample(input brr_in_t item);
		int               v;
		int               mark;
		int               dev;
		int               best;
		logic [SUM_W-1:0] least;
		logic [MARK_W-1:0] lo;
		brr_out_t         b;
		v = $signed(item.sample);
		if (item.final_block)
			end_seen = 1'b1;
		for (int r = 0; r < NUM_RANGES; r++) begin
			nearest_mark(v, r, mark, dev);
			mark_tab[r][block_fill] = mark[MARK_W-1:0];
			dev_sum[r] = dev_sum[r] + dev[SUM_W-1:0];
		end
		if (block_fill < BLOCK_SAMPLES - 1) begin
			block_fill++;
		end else begin
			// least sum wins, lowest range on a tie
			best  = 0;
			least = dev_sum[0];
			for (int r = 1; r < NUM_RANGES; r++) begin
				if (dev_sum[r] < least) begin
					least = dev_sum[r];
					best  = r;
				end
			end
			b.out_byte      = {best[3:0], 3'b000, end_seen};
			b.last_of_block = 1'b0;
			expected_bytes.push_back(b);
			for (int k = 0; k < BLOCK_SAMPLES; k += 2) begin
				lo = (k + 1 < BLOCK_SAMPLES) ? mark_tab[best][k+1] : '0;
				b.out_byte      = {mark_tab[best][k], lo};
				b.last_of_block = (k + 2 >= BLOCK_SAMPLES);
				expected_bytes.push_back(b);
			end
			block_fill = 0;
			end_seen   = 1'b0;
			for (int r = 0; r < NUM_RANGES; r++)
				dev_sum[r] = '0;
		end
	endtask

	task automatic flag_mismatch(input string what, input int want, input int got);
		$display("error: byte %0d %s expected 0x%02h got 0x%02h",
			bytes_seen, what, want, got);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	task automatic push_sample(input int v, input bit fin);
		brr_in_t s;
		s.sample      = v[SAMPLE_W-1:0];
		s.final_block = fin;
		pending_samples.push_back(s);
		samples_total++;
	endtask

	task automatic build_block(input block_kind_t kind);
		int r;
		int step;
		int span;
		int v;
		int flat_v;
		int fin_mode;
		int fin_pos;
		bit fin;
		r        = $urandom_range(0, NUM_RANGES - 1);
		step     = 1 << r;
		span     = 9 * step;
		flat_v   = int'($urandom_range(0, 65535)) - 32768;
		// mostly no end flag; sometimes on one sample, sometimes on all
		fin_mode = $urandom_range(0, 5);
		fin_pos  = $urandom_range(0, BLOCK_SAMPLES - 1);
		for (int i = 0; i < BLOCK_SAMPLES; i++) begin
			case (kind)
				KIND_FULL: begin
					v = int'($urandom_range(0, 65535)) - 32768;
				end
				KIND_SCALED: begin
					if (r > 0 && $urandom_range(0, 3) == 0) begin
						// exactly halfway between two grid points
						v = int'($urandom_range(0, 8)) * step + step / 2;
						if ($urandom_range(0, 1))
							v = -v;
					end else begin
						v = int'($urandom_range(0, 2 * span)) - span;
					end
				end
				KIND_EXTREME: begin
					case ($urandom_range(0, 4))
						0: v = 32767;
						1: v = -32768;
						2: v = 0;
						3: v = 1;
						default: v = -1;
					endcase
				end
				default: begin
					v = flat_v;
				end
			endcase
			case (fin_mode)
				0: fin = (i == fin_pos);
				1: fin = 1'b1;
				default: fin = 1'b0;
			endcase
			push_sample(clamp16(v), fin);
		end
	endtask

	// ------------------------------------------------------------------
	// Input driver: changes at the falling edge, holds until accepted
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic    nv;
		brr_in_t nd;
		nv = in_valid;
		nd = in_data;
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_idle_left > 0) begin
				in_idle_left--;
				nv = 1'b0;
			end else if (pending_samples.size() >= QUIET_TAIL &&
					$urandom_range(0, 7) == 0) begin
				// start an idle burst; this cycle counts as part of it
				in_idle_left = $urandom_range(0, 15);
				nv = 1'b0;
			end else if (pending_samples.size() > 0) begin
				nd = pending_samples.pop_front();
				nv = 1'b1;
			end else begin
				nv = 1'b0;
			end
		end
		in_valid <= nv;
		in_data  <= nd;
	end

	// ------------------------------------------------------------------
	// Output back-pressure: random stall bursts, none near the end
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic nr;
		nr = 1'b1;
		if (!arst_n) begin
			nr = 1'b0;
		end else if (out_idle_left > 0) begin
			out_idle_left--;
			nr = 1'b0;
		end else if (pending_samples.size() >= QUIET_TAIL &&
				$urandom_range(0, 9) == 0) begin
			out_idle_left = $urandom_range(0, 15);
			nr = 1'b0;
		end
		out_ready <= nr;
	end

	// ------------------------------------------------------------------
	// Monitor: both handshakes sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		brr_out_t want;
		brr_out_t got;
		in_fire = arst_n && in_valid && in_ready;
		if (in_fire) begin
			encode_sample(in_data);
			samples_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			got = out_data;
			if (expected_bytes.size() == 0) begin
				flag_mismatch("unexpected, none pending", 0, got.out_byte);
			end else begin
				want = expected_bytes.pop_front();
				if (got.out_byte !== want.out_byte)
					flag_mismatch("out_byte", want.out_byte, got.out_byte);
				if (got.last_of_block !== want.last_of_block)
					flag_mismatch("last_of_block", want.last_of_block,
						got.last_of_block);
			end
			bytes_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		for (int r = 0; r < NUM_RANGES; r++)
			dev_sum[r] = '0;

		// directed block: full scale both ways, zero, unit steps, ties
		// toward the smaller mark, clamp points, end flag on last sample
		push_sample(32767, 1'b0);
		push_sample(-32768, 1'b0);
		push_sample(0, 1'b0);
		push_sample(1, 1'b0);
		push_sample(-1, 1'b0);
		push_sample(2, 1'b0);
		push_sample(3, 1'b0);       // tie between marks 1 and 2 at range 1
		push_sample(-3, 1'b0);
		push_sample(28672, 1'b0);   // 7 * 4096, top positive mark
		push_sample(30720, 1'b0);   // halfway past the positive clamp
		push_sample(-32767, 1'b0);
		push_sample(6144, 1'b0);    // tie at range 12
		push_sample(-6144, 1'b0);
		push_sample(16, 1'b0);
		push_sample(-16, 1'b0);
		push_sample(100, 1'b1);

		for (int b = 0; b < RAND_BLOCKS; b++)
			build_block(block_kind_t'($urandom_range(0, 3)));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (samples_taken < samples_total)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		// let any straggler byte show up as unexpected
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_bytes.size() != 0)
			flag_mismatch("left over at end", expected_bytes.size(), 0);

		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
